FILE: rtl/bisq_pkg.sv
package bisq_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_HITS    = 16;
    localparam int LABEL_BITS  = 8;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int HIT_W  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int HCNT_W = $clog2(MAX_HITS + 1);

    // Distance unit widths: differences stay below 2^35 in magnitude.
    localparam int DIFF_W = 36;
    localparam int MAG_W  = 36;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RAD_W  = SQ_W + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int DCNT_W = 6;

    localparam int S_DATA_W = 312;
    localparam int M_DATA_W = 104;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_LABEL  = 3'd2;
    localparam logic [2:0] CMD_NEAR   = 3'd3;
    localparam logic [2:0] CMD_REGION = 3'd4;
    localparam logic [2:0] CMD_REL    = 3'd5;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_BAD_ARG  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [1:0] DS_BOUND  = 2'd0;
    localparam logic [1:0] DS_CENTER = 2'd1;
    localparam logic [1:0] DS_SEP    = 2'd2;
    localparam logic [1:0] DS_CTR    = 2'd3;

    localparam logic [1:0] OK_SINGLE = 2'd0;
    localparam logic [1:0] OK_REL    = 2'd1;
    localparam logic [1:0] OK_LIST   = 2'd2;

    typedef struct packed {
        logic signed [31:0] hi_z;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_x;
        logic signed [31:0] lo_z;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_x;
    } box_t;

    typedef struct packed {
        logic [31:0]           id;
        logic [LABEL_BITS-1:0] label;
        box_t                  box;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef struct packed {
        logic       accept;
        logic       clear_tbl;
        logic       rd_scan;
        logic       rd_sub;
        logic       rd_ref;
        logic       scan_chk;
        logic       latch_sub;
        logic       dist_go;
        logic [1:0] dist_sel;
        logic       latch_bd;
        logic       best_ins;
        logic       wr_ent;
        logic       out_ld;
        logic [1:0] out_kind;
        logic [2:0] out_status;
        logic       out_id_sel;
        logic       list_next;
    } bisq_ctl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       arg_bad;
        logic       scan_end;
        logic       lbl_ok;
        logic       hit;
        logic       dist_done;
        logic       in_bound;
        logic       dup;
        logic       found_s;
        logic       found_r;
        logic       full;
        logic       best_empty;
        logic       list_last;
        logic       out_free;
    } bisq_sts_t;

endpackage

FILE: rtl/bisq_ram.sv
module bisq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bisq_dist.sv
module bisq_dist
    import bisq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    input  logic signed [DIFF_W-1:0] dz,
    output logic                     busy,
    output logic                     done,
    output logic [ROOT_W-1:0]        root
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_SUM  = 2'd2;
    localparam logic [1:0] D_ROOT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [SQ_W-1:0]   mcand_reg [3];
    logic [SQ_W-1:0]   mcand_next [3];
    logic [SQ_W-1:0]   acc_reg [3];
    logic [SQ_W-1:0]   acc_next [3];
    logic [MAG_W-1:0]  mplier_reg [3];
    logic [MAG_W-1:0]  mplier_next [3];
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_t, trial;
    logic signed [DIFF_W-1:0] d [3];
    logic [MAG_W-1:0]  mag [3];

    always_comb
    begin
        d[0] = dx;
        d[1] = dy;
        d[2] = dz;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = d[k][DIFF_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
        end
    end

    // Squares by shift and add, then a restoring root,
    // one result bit per cycle.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        for (int k = 0; k < 3; k++)
        begin
            mcand_next[k]  = mcand_reg[k];
            mplier_next[k] = mplier_reg[k];
            acc_next[k]    = acc_reg[k];
        end
        rem_t = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial = REM_W'({root_reg, 2'b01});
        unique case (state_reg)
            D_IDLE:
            begin
                if (go)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mcand_next[k]  = SQ_W'(mag[k]);
                        mplier_next[k] = mag[k];
                        acc_next[k]    = '0;
                    end
                    cnt_next   = '0;
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (mplier_reg[k][0])
                    begin
                        acc_next[k] = acc_reg[k] + mcand_reg[k];
                    end
                    mcand_next[k]  = mcand_reg[k] << 1;
                    mplier_next[k] = mplier_reg[k] >> 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(MAG_W - 1))
                begin
                    state_next = D_SUM;
                end
            end
            D_SUM:
            begin
                rad_next   = RAD_W'(acc_reg[0]) + RAD_W'(acc_reg[1]) + RAD_W'(acc_reg[2]);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = D_ROOT;
            end
            D_ROOT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(ROOT_W - 1))
                begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mcand_reg[k]  <= mcand_next[k];
            mplier_reg[k] <= mplier_next[k];
            acc_reg[k]    <= acc_next[k];
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (state_reg != D_IDLE);
    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/bisq_dp.sv
module bisq_dp
    import bisq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast,
    input  bisq_ctl_t           ctl,
    output bisq_sts_t           sts
);

    // Latched item.
    logic [2:0]            op_reg;
    logic [31:0]           item_id_reg;
    logic [31:0]           ref_id_reg;
    logic [LABEL_BITS-1:0] lab_reg;
    box_t                  in_box_reg;
    logic [31:0]           limit_reg;
    logic [HCNT_W-1:0]     cap_reg;

    // Table and scan state.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              found_s_reg, found_r_reg;
    logic [IDX_W-1:0]  pos_s_reg, pos_r_reg;
    box_t              sub_box_reg;
    logic [ROOT_W-1:0] bd_reg;

    // Ranked hit list.
    logic [31:0]       best_id_reg [MAX_HITS];
    logic [63:0]       best_key_reg [MAX_HITS];
    logic [HCNT_W-1:0] best_cnt_reg;
    logic [HIT_W-1:0]  list_idx_reg;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_id_reg, out_bd_reg, out_cd_reg;
    logic        out_ovl_reg, out_holds_reg, out_held_reg, out_near_reg, out_last_reg;
    logic [2:0]  out_status_next;
    logic [31:0] out_id_next, out_bd_next, out_cd_next;
    logic        out_ovl_next, out_holds_next, out_held_next, out_near_next, out_last_next;

    logic [ENT_W-1:0]  rdata;
    entry_t            ent;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [15:0]       budget;
    logic              box_ok;
    logic              arg_bad;
    logic              dist_busy, dist_done;
    logic [ROOT_W-1:0] root;
    logic signed [DIFF_W-1:0] d [3];
    logic signed [31:0] pt [3];
    logic signed [31:0] elo [3];
    logic signed [31:0] ehi [3];
    logic signed [31:0] slo [3];
    logic signed [31:0] shi [3];
    logic [31:0]       cd_sat;
    logic [31:0]       new_id;
    logic [63:0]       new_key;
    logic              gt [MAX_HITS];
    logic              prev_gt [MAX_HITS];
    logic              upd [MAX_HITS];
    logic [31:0]       ins_id [MAX_HITS];
    logic [63:0]       ins_key [MAX_HITS];
    logic              out_free;

    function automatic logic signed [DIFF_W-1:0] ext(input logic signed [31:0] v);
        return {{(DIFF_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [DIFF_W-1:0] clamp_diff(
        input logic signed [31:0] p,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [DIFF_W-1:0] r;
        if (p < lo)
        begin
            r = ext(p) - ext(lo);
        end
        else if (p > hi)
        begin
            r = ext(p) - ext(hi);
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] mid_diff(
        input logic signed [31:0] a1,
        input logic signed [31:0] a2,
        input logic signed [31:0] b1,
        input logic signed [31:0] b2
    );
        return (ext(a1) + ext(a2)) - (ext(b1) + ext(b2));
    endfunction

    function automatic logic signed [DIFF_W-1:0] gap(
        input logic signed [31:0] alo,
        input logic signed [31:0] ahi,
        input logic signed [31:0] blo,
        input logic signed [31:0] bhi
    );
        logic signed [DIFF_W-1:0] g1, g2, g;
        g1 = ext(alo) - ext(bhi);
        g2 = ext(blo) - ext(ahi);
        g  = (g1 > g2) ? g1 : g2;
        return (g > 0) ? g : '0;
    endfunction

    function automatic logic meets(input box_t a, input box_t b);
        return (a.lo_x <= b.hi_x) && (a.hi_x >= b.lo_x) &&
               (a.lo_y <= b.hi_y) && (a.hi_y >= b.lo_y) &&
               (a.lo_z <= b.hi_z) && (a.hi_z >= b.lo_z);
    endfunction

    function automatic logic holds(input box_t o, input box_t i);
        return (o.lo_x <= i.lo_x) && (o.hi_x >= i.hi_x) &&
               (o.lo_y <= i.lo_y) && (o.hi_y >= i.hi_y) &&
               (o.lo_z <= i.lo_z) && (o.hi_z >= i.hi_z);
    endfunction

    bisq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.wr_ent),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ENT_W'({item_id_reg, lab_reg, in_box_reg})),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ent = entry_t'(rdata);
    assign re  = ctl.rd_scan | ctl.rd_sub | ctl.rd_ref;

    always_comb
    begin
        if (ctl.rd_sub)
        begin
            raddr = pos_s_reg;
        end
        else if (ctl.rd_ref)
        begin
            raddr = pos_r_reg;
        end
        else
        begin
            raddr = idx_reg[IDX_W-1:0];
        end
    end

    assign budget = s_tdata[279:264];

    assign box_ok = (in_box_reg.lo_x <= in_box_reg.hi_x) &&
                    (in_box_reg.lo_y <= in_box_reg.hi_y) &&
                    (in_box_reg.lo_z <= in_box_reg.hi_z);

    always_comb
    begin
        case (op_reg)
            CMD_CLEAR:  arg_bad = 1'b0;
            CMD_LOAD:   arg_bad = (item_id_reg == '0) || !box_ok;
            CMD_REL:    arg_bad = (item_id_reg == '0) || (ref_id_reg == '0) ||
                                  (item_id_reg == ref_id_reg);
            CMD_LABEL:  arg_bad = (cap_reg == '0) || (lab_reg == '0);
            CMD_NEAR:   arg_bad = (cap_reg == '0);
            CMD_REGION: arg_bad = (cap_reg == '0) || !box_ok;
            default:    arg_bad = 1'b1;
        endcase
    end

    // Axis operands for the distance unit.
    always_comb
    begin
        pt[0]  = in_box_reg.lo_x;
        pt[1]  = in_box_reg.lo_y;
        pt[2]  = in_box_reg.lo_z;
        elo[0] = ent.box.lo_x;
        elo[1] = ent.box.lo_y;
        elo[2] = ent.box.lo_z;
        ehi[0] = ent.box.hi_x;
        ehi[1] = ent.box.hi_y;
        ehi[2] = ent.box.hi_z;
        slo[0] = sub_box_reg.lo_x;
        slo[1] = sub_box_reg.lo_y;
        slo[2] = sub_box_reg.lo_z;
        shi[0] = sub_box_reg.hi_x;
        shi[1] = sub_box_reg.hi_y;
        shi[2] = sub_box_reg.hi_z;
        for (int k = 0; k < 3; k++)
        begin
            case (ctl.dist_sel)
                DS_BOUND:  d[k] = clamp_diff(pt[k], elo[k], ehi[k]);
                DS_CENTER: d[k] = mid_diff(pt[k], pt[k], elo[k], ehi[k]);
                DS_SEP:    d[k] = gap(slo[k], shi[k], elo[k], ehi[k]);
                default:   d[k] = mid_diff(slo[k], shi[k], elo[k], ehi[k]);
            endcase
        end
    end

    bisq_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (ctl.dist_go),
        .dx    (d[0]),
        .dy    (d[1]),
        .dz    (d[2]),
        .busy  (dist_busy),
        .done  (dist_done),
        .root  (root)
    );

    // Centre roots are taken over doubled coordinates, so halve them.
    assign cd_sat = (|root[ROOT_W-1:33]) ? 32'hFFFF_FFFF : root[32:1];

    assign new_id  = ent.id;
    assign new_key = (op_reg == CMD_NEAR) ? {bd_reg[31:0], cd_sat} : 64'd0;

    // Insertion into the sorted list: every slot past the new rank
    // takes its left neighbor, the slot at the rank takes the new hit.
    always_comb
    begin
        for (int p = 0; p < MAX_HITS; p++)
        begin
            gt[p] = (HCNT_W'(p) >= best_cnt_reg) ||
                    (new_key < best_key_reg[p]) ||
                    ((new_key == best_key_reg[p]) && (new_id < best_id_reg[p]));
            upd[p] = gt[p] && (HCNT_W'(p) < cap_reg);
        end
        prev_gt[0] = 1'b0;
        ins_id[0]  = new_id;
        ins_key[0] = new_key;
        for (int p = 1; p < MAX_HITS; p++)
        begin
            prev_gt[p] = gt[p-1];
            ins_id[p]  = prev_gt[p] ? best_id_reg[p-1] : new_id;
            ins_key[p] = prev_gt[p] ? best_key_reg[p-1] : new_key;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_status_next = ST_HIT;
        out_id_next     = '0;
        out_bd_next     = '0;
        out_cd_next     = '0;
        out_ovl_next    = 1'b0;
        out_holds_next  = 1'b0;
        out_held_next   = 1'b0;
        out_near_next   = 1'b0;
        out_last_next   = 1'b1;
        case (ctl.out_kind)
            OK_REL:
            begin
                out_id_next    = item_id_reg;
                out_bd_next    = (|bd_reg[ROOT_W-1:32]) ? 32'hFFFF_FFFF : bd_reg[31:0];
                out_cd_next    = cd_sat;
                out_ovl_next   = meets(sub_box_reg, ent.box);
                out_holds_next = holds(sub_box_reg, ent.box);
                out_held_next  = holds(ent.box, sub_box_reg);
                out_near_next  = (bd_reg <= ROOT_W'(limit_reg));
            end
            OK_LIST:
            begin
                out_id_next = best_id_reg[list_idx_reg];
                if (op_reg == CMD_NEAR)
                begin
                    out_bd_next = best_key_reg[list_idx_reg][63:32];
                    out_cd_next = best_key_reg[list_idx_reg][31:0];
                end
                out_last_next = sts.list_last;
            end
            default:
            begin
                out_status_next = ctl.out_status;
                out_id_next     = ctl.out_id_sel ? item_id_reg : 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            found_s_reg   <= 1'b0;
            found_r_reg   <= 1'b0;
            best_cnt_reg  <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                idx_reg      <= '0;
                found_s_reg  <= 1'b0;
                found_r_reg  <= 1'b0;
                best_cnt_reg <= '0;
                list_idx_reg <= '0;
            end
            if (ctl.clear_tbl)
            begin
                count_reg <= '0;
            end
            else if (ctl.wr_ent)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctl.scan_chk)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ent.id == item_id_reg)
                begin
                    found_s_reg <= 1'b1;
                end
                if (ent.id == ref_id_reg)
                begin
                    found_r_reg <= 1'b1;
                end
            end
            if (ctl.best_ins && (best_cnt_reg < cap_reg))
            begin
                best_cnt_reg <= best_cnt_reg + 1'b1;
            end
            if (ctl.list_next)
            begin
                list_idx_reg <= list_idx_reg + 1'b1;
            end
            if (ctl.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_reg      <= s_tuser;
            item_id_reg <= s_tdata[31:0];
            ref_id_reg  <= s_tdata[63:32];
            lab_reg     <= s_tdata[64 +: LABEL_BITS];
            in_box_reg  <= box_t'(s_tdata[263:72]);
            limit_reg   <= s_tdata[311:280];
            cap_reg     <= (budget > 16'(MAX_HITS)) ? HCNT_W'(MAX_HITS) : HCNT_W'(budget);
        end
        if (ctl.scan_chk)
        begin
            if (ent.id == item_id_reg)
            begin
                pos_s_reg <= idx_reg[IDX_W-1:0];
            end
            if (ent.id == ref_id_reg)
            begin
                pos_r_reg <= idx_reg[IDX_W-1:0];
            end
        end
        if (ctl.latch_sub)
        begin
            sub_box_reg <= ent.box;
        end
        if (ctl.latch_bd)
        begin
            bd_reg <= root;
        end
        if (ctl.best_ins)
        begin
            for (int p = 0; p < MAX_HITS; p++)
            begin
                if (upd[p])
                begin
                    best_id_reg[p]  <= ins_id[p];
                    best_key_reg[p] <= ins_key[p];
                end
            end
        end
        if (ctl.out_ld)
        begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_bd_reg     <= out_bd_next;
            out_cd_reg     <= out_cd_next;
            out_ovl_reg    <= out_ovl_next;
            out_holds_reg  <= out_holds_next;
            out_held_reg   <= out_held_next;
            out_near_reg   <= out_near_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.arg_bad    = arg_bad;
        sts.scan_end   = (idx_reg == count_reg);
        sts.lbl_ok     = (lab_reg == '0) || (ent.label == lab_reg);
        sts.hit        = sts.lbl_ok &&
                         ((op_reg == CMD_LABEL) ||
                          ((op_reg == CMD_REGION) && meets(in_box_reg, ent.box)));
        sts.dist_done  = dist_done;
        sts.in_bound   = (root <= ROOT_W'(limit_reg));
        sts.dup        = found_s_reg;
        sts.found_s    = found_s_reg;
        sts.found_r    = found_r_reg;
        sts.full       = (count_reg == CNT_W'(TABLE_DEPTH));
        sts.best_empty = (best_cnt_reg == '0);
        sts.list_last  = ((HCNT_W'(list_idx_reg) + 1'b1) == best_cnt_reg);
        sts.out_free   = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_near_reg, out_held_reg, out_holds_reg, out_ovl_reg,
                       out_cd_reg, out_bd_reg, out_id_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_ent |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("table write did not advance the entry count");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_ld |-> out_free)
        else $error("result register overwritten before it was taken");

    a_dist_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dist_go |-> !dist_busy)
        else $error("distance unit started while busy");

endmodule

FILE: rtl/bisq_ctrl.sv
module bisq_ctrl
    import bisq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bisq_sts_t sts,
    output bisq_ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_BD_WAIT  = 4'd4;
    localparam logic [3:0] S_CD_WAIT  = 4'd5;
    localparam logic [3:0] S_SCAN_END = 4'd6;
    localparam logic [3:0] S_REL_RDS  = 4'd7;
    localparam logic [3:0] S_REL_RDR  = 4'd8;
    localparam logic [3:0] S_REL_GO   = 4'd9;
    localparam logic [3:0] S_SEP_WAIT = 4'd10;
    localparam logic [3:0] S_CTR_WAIT = 4'd11;
    localparam logic [3:0] S_LIST     = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [2:0] code_reg, code_next;
    logic       idsel_reg, idsel_next;

    always_comb
    begin
        ctl            = '0;
        ctl.out_kind   = kind_reg;
        ctl.out_status = code_reg;
        ctl.out_id_sel = idsel_reg;
        state_next     = state_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        idsel_next     = idsel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.arg_bad)
                begin
                    kind_next  = OK_SINGLE;
                    code_next  = ST_BAD_ARG;
                    idsel_next = 1'b0;
                    state_next = S_EMIT;
                end
                else if (sts.op == CMD_CLEAR)
                begin
                    ctl.clear_tbl = 1'b1;
                    kind_next     = OK_SINGLE;
                    code_next     = ST_HIT;
                    idsel_next    = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                ctl.scan_chk = 1'b1;
                if ((sts.op == CMD_NEAR) && sts.lbl_ok)
                begin
                    ctl.dist_go  = 1'b1;
                    ctl.dist_sel = DS_BOUND;
                    state_next   = S_BD_WAIT;
                end
                else
                begin
                    ctl.best_ins = sts.hit;
                    state_next   = S_SCAN_RD;
                end
            end
            S_BD_WAIT:
            begin
                if (sts.dist_done)
                begin
                    if (sts.in_bound)
                    begin
                        ctl.latch_bd = 1'b1;
                        ctl.dist_go  = 1'b1;
                        ctl.dist_sel = DS_CENTER;
                        state_next   = S_CD_WAIT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_CD_WAIT:
            begin
                if (sts.dist_done)
                begin
                    ctl.best_ins = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_END:
            begin
                kind_next  = OK_SINGLE;
                idsel_next = 1'b0;
                state_next = S_EMIT;
                if (sts.op == CMD_LOAD)
                begin
                    if (sts.dup)
                    begin
                        code_next = ST_BAD_ARG;
                    end
                    else if (sts.full)
                    begin
                        code_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.wr_ent = 1'b1;
                        code_next  = ST_HIT;
                        idsel_next = 1'b1;
                    end
                end
                else if (sts.op == CMD_REL)
                begin
                    if (sts.found_s && sts.found_r)
                    begin
                        state_next = S_REL_RDS;
                    end
                    else
                    begin
                        code_next = ST_NOTFOUND;
                    end
                end
                else if (sts.best_empty)
                begin
                    code_next = ST_NONE;
                end
                else
                begin
                    state_next = S_LIST;
                end
            end
            S_REL_RDS:
            begin
                ctl.rd_sub = 1'b1;
                state_next = S_REL_RDR;
            end
            S_REL_RDR:
            begin
                ctl.latch_sub = 1'b1;
                ctl.rd_ref    = 1'b1;
                state_next    = S_REL_GO;
            end
            S_REL_GO:
            begin
                ctl.dist_go  = 1'b1;
                ctl.dist_sel = DS_SEP;
                state_next   = S_SEP_WAIT;
            end
            S_SEP_WAIT:
            begin
                if (sts.dist_done)
                begin
                    ctl.latch_bd = 1'b1;
                    ctl.dist_go  = 1'b1;
                    ctl.dist_sel = DS_CTR;
                    state_next   = S_CTR_WAIT;
                end
            end
            S_CTR_WAIT:
            begin
                if (sts.dist_done)
                begin
                    kind_next  = OK_REL;
                    state_next = S_EMIT;
                end
            end
            S_LIST:
            begin
                ctl.out_kind = OK_LIST;
                if (sts.out_free)
                begin
                    ctl.out_ld    = 1'b1;
                    ctl.list_next = 1'b1;
                    if (sts.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        code_reg  <= code_next;
        idsel_reg <= idsel_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

FILE: rtl/box_index_spatial_query.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata (request fields), s_tuser (command)
// m_       out  m_tvalid/m_tready  m_tdata (result fields), m_tuser (status), m_tlast
//
// One item is worked on at a time. A clear or a rejected item goes straight to its result.
// Loads, label and region queries scan the table, reading then checking each stored entry;
// a load then sends one result, label and region queries one hit per cycle that the output is free.
// A nearest query works out a distance root (shift-add squares, then a bit-serial root)
// for each entry whose label matches and a second one for each entry within the bound; a relation
// takes a table scan, then reads both entries and works out two roots. Reset empties the table at once.
module box_index_spatial_query
    import bisq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // item_id, ref_id, label, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, budget, distance_limit
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit_id, bound_dist, center_dist, overlap, holds_other, held_by_other, is_near, pad
    output logic [M_DATA_W-1:0] m_tdata,
    // status
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    bisq_ctl_t ctl;
    bisq_sts_t sts;

    bisq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bisq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule
